/* sv/rtp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the rigid point transform block.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // rotation entries are Q4.30 with headroom for rounding past +/-2.0
  localparam int unsigned ENTRY_BITS = 34;
  localparam int unsigned ROT_FRAC   = 30;
  localparam int unsigned NORM_BITS  = 31;   // signed normalised component
  localparam int unsigned PROD_BITS  = 62;   // NORM_BITS + NORM_BITS
  localparam int unsigned TERM_BITS  = 33;   // |t| >> 30
  localparam int unsigned INV_BITS   = 35;   // floor(2^62 / m)
  localparam int unsigned INV_LO     = 18;
  localparam int unsigned ACC_BITS   = 68;
  localparam int unsigned DIV_STEPS  = 63;

  localparam logic [ENTRY_BITS-1:0] ONE_Q30 = ENTRY_BITS'(1) << ROT_FRAC;

  localparam logic [2:0] REG_QX   = 3'd0;
  localparam logic [2:0] REG_QY   = 3'd1;
  localparam logic [2:0] REG_QZ   = 3'd2;
  localparam logic [2:0] REG_QW   = 3'd3;
  localparam logic [2:0] REG_SX   = 3'd4;
  localparam logic [2:0] REG_SY   = 3'd5;
  localparam logic [2:0] REG_SZ   = 3'd6;
  localparam logic [2:0] NUM_REGS = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_PROD,
    ST_SUMS,
    ST_DIV,
    ST_TERM
  } drv_state_e;

endpackage

/* sv/rtp_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_in_if
// Input point channel: valid/ready handshake with three coordinates.
// ----------------------------------------------------------------------------
interface rtp_in_if #(
  parameter int unsigned COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

/* sv/rtp_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_out_if
// Result channel: transformed point and saturation flag.
// ----------------------------------------------------------------------------
interface rtp_out_if #(
  parameter int unsigned COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] moved_x;
  logic signed [COORD_BITS-1:0] moved_y;
  logic signed [COORD_BITS-1:0] moved_z;
  logic                         clipped;

  modport source (output valid, moved_x, moved_y, moved_z, clipped, input ready);
  modport sink   (input valid, moved_x, moved_y, moved_z, clipped, output ready);
endinterface

/* sv/rigid_transform_points_top.sv */
`timescale 1ns / 1ps
// input, product and result registers; one point per cycle unless output stalls
// three lanes, one per output coordinate, each with three registered multipliers
// a configuration write re-derives the matrix (normalise, products, sums, divider,
// terms), no point accepted meanwhile; a zero quaternion returns to the identity
// reset: identity rotation, zero translation, ready at once
// ----------------------------------------------------------------------------
// rigid_transform_points_top
// Rotates points by a quaternion-derived matrix and translates them.
// ----------------------------------------------------------------------------
module rigid_transform_points_top #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtp_in_if.sink                in_ch,
  rtp_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  logic signed [rtp_pkg::ENTRY_BITS-1:0] rot [9];
  logic signed [COORD_BITS-1:0]          shift [3];
  logic                                  drv_ready;
  logic                                  en;
  logic                                  v1_q, v2_q, ov_q;
  logic signed [COORD_BITS-1:0]          pt_q [3];
  logic signed [COORD_BITS-1:0]          res [3];
  logic [2:0]                            clip;
  logic signed [COORD_BITS-1:0]          mx_q, my_q, mz_q;
  logic                                  clip_q;

  rtp_derive #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_derive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .rot_o     (rot),
    .shift_o   (shift),
    .ready_o   (drv_ready)
  );

  assign en          = !ov_q || out_ch.ready;
  assign in_ch.ready = drv_ready && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_ch.valid && drv_ready;
      v2_q <= v1_q;
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[0] <= in_ch.point_x;
      pt_q[1] <= in_ch.point_y;
      pt_q[2] <= in_ch.point_z;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [rtp_pkg::ENTRY_BITS-1:0] row [3];
    assign row[0] = rot[3*i];
    assign row[1] = rot[3*i+1];
    assign row[2] = rot[3*i+2];

    rtp_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .row_i  (row),
      .pt_i   (pt_q),
      .shift_i(shift[i]),
      .res_o  (res[i]),
      .clip_o (clip[i])
    );
  end

  // merge the lanes into one result item
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= res[0];
      my_q   <= res[1];
      mz_q   <= res[2];
      clip_q <= |clip;
    end
  end

  assign out_ch.valid   = ov_q;
  assign out_ch.moved_x = mx_q;
  assign out_ch.moved_y = my_q;
  assign out_ch.moved_z = mz_q;
  assign out_ch.clipped = clip_q;

endmodule

/* sv/rtp_derive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_derive
// Configuration registers and sequencer deriving the rotation matrix.
// ----------------------------------------------------------------------------
module rtp_derive #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [2:0]                              cfg_idx_i,
  input  logic [COORD_BITS-1:0]                   cfg_data_i,
  output logic signed [rtp_pkg::ENTRY_BITS-1:0]   rot_o [9],
  output logic signed [COORD_BITS-1:0]            shift_o [3],
  output logic                                    ready_o
);

  localparam int unsigned LW = $clog2(COORD_BITS + 1);
  localparam int unsigned SW = COORD_BITS + 30;
  localparam int unsigned NB = rtp_pkg::NORM_BITS;
  localparam int unsigned PB = rtp_pkg::PROD_BITS;
  localparam int unsigned TB = rtp_pkg::TERM_BITS;
  localparam int unsigned IB = rtp_pkg::INV_BITS;
  localparam int unsigned IL = rtp_pkg::INV_LO;
  localparam int unsigned AB = rtp_pkg::ACC_BITS;
  localparam int unsigned EB = rtp_pkg::ENTRY_BITS;

  rtp_pkg::drv_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] q_q [4];
  logic signed [COORD_BITS-1:0] sh_q [3];
  logic signed [NB-1:0]         qs_q [4];
  logic signed [PB-1:0]         pr_q [10];
  logic [31:0]                  m_q;
  logic [TB-1:0]                tm_q [9];
  logic [8:0]                   tneg_q;
  logic [31:0]                  rem_q;
  logic [IB-1:0]                inv_q;
  logic [5:0]                   dcnt_q;
  logic [3:0]                   ecnt_q;
  logic [1:0]                   sub_q;
  logic [AB-1:0]                acc_q;
  logic signed [EB-1:0]         rot_q [9];

  logic                         cfg_hit;
  logic [COORD_BITS-1:0]        mag [4];
  logic [COORD_BITS-1:0]        mx;
  logic [LW-1:0]                len;
  logic signed [NB-1:0]         qs_d [4];
  logic [63:0]                  n_sum;
  logic signed [63:0]           tval [9];
  logic [63:0]                  tmag [9];
  logic [32:0]                  trial;
  logic                         qbit;
  logic [TB+IL-1:0]             pp_lo;
  logic [TB+IB-IL-1:0]          pp_hi;
  logic [35:0]                  e_val;
  logic signed [EB:0]           s_val;
  logic signed [EB:0]           ent;
  logic                         diag;
  logic                         last_div;
  logic                         last_term;

  assign cfg_hit   = cfg_we_i && (cfg_idx_i < rtp_pkg::NUM_REGS);
  assign last_div  = (dcnt_q == 6'(rtp_pkg::DIV_STEPS - 1));
  assign last_term = (ecnt_q == 4'd8) && (sub_q == 2'd2);

  // normalise so the largest magnitude sits in [2^29, 2^30)
  always_comb begin
    logic [SW-1:0] wide;
    mx  = '0;
    len = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = q_q[i][COORD_BITS-1] ? COORD_BITS'(-q_q[i]) : COORD_BITS'(q_q[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    for (int b = 0; b < COORD_BITS; b++) begin
      if (mx[b]) len = LW'(b + 1);
    end
    for (int i = 0; i < 4; i++) begin
      wide = SW'(mag[i]);
      if (len > LW'(30)) wide = wide >> (len - LW'(30));
      else               wide = wide << (LW'(30) - len);
      qs_d[i] = q_q[i][COORD_BITS-1] ? -NB'(wide[29:0]) : NB'(wide[29:0]);
    end
  end

  // products: xx yy zz ww xy zw xz yw yz xw
  always_comb begin
    n_sum = 64'(pr_q[0]) + 64'(pr_q[1]) + 64'(pr_q[2]) + 64'(pr_q[3]);
    tval[0] = (64'(pr_q[1]) + 64'(pr_q[2])) <<< 1;
    tval[1] = (64'(pr_q[4]) - 64'(pr_q[5])) <<< 1;
    tval[2] = (64'(pr_q[6]) + 64'(pr_q[7])) <<< 1;
    tval[3] = (64'(pr_q[4]) + 64'(pr_q[5])) <<< 1;
    tval[4] = (64'(pr_q[0]) + 64'(pr_q[2])) <<< 1;
    tval[5] = (64'(pr_q[8]) - 64'(pr_q[9])) <<< 1;
    tval[6] = (64'(pr_q[6]) - 64'(pr_q[7])) <<< 1;
    tval[7] = (64'(pr_q[8]) + 64'(pr_q[9])) <<< 1;
    tval[8] = (64'(pr_q[0]) + 64'(pr_q[1])) <<< 1;
    for (int k = 0; k < 9; k++) begin
      tmag[k] = tval[k][63] ? 64'(-tval[k]) : 64'(tval[k]);
    end
  end

  // restoring division of 2^62 by m, one quotient bit per cycle
  assign trial = {rem_q, (dcnt_q == 6'd0)};
  assign qbit  = (trial >= {1'b0, m_q});

  assign pp_lo = TB'(tm_q[ecnt_q]) * inv_q[IL-1:0];
  assign pp_hi = TB'(tm_q[ecnt_q]) * inv_q[IB-1:IL];
  assign diag  = (ecnt_q == 4'd0) || (ecnt_q == 4'd4) || (ecnt_q == 4'd8);
  assign e_val = acc_q[AB-1:32];
  assign s_val = tneg_q[ecnt_q] ? -(EB+1)'(e_val) : (EB+1)'(e_val);
  assign ent   = diag ? ((EB+1)'(rtp_pkg::ONE_Q30) - s_val) : s_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ready_o = 1'b0;
    case (state_q)
      rtp_pkg::ST_IDLE: begin
        ready_o = !cfg_hit;
        if (cfg_hit) state_d = rtp_pkg::ST_NORM;
      end
      rtp_pkg::ST_NORM: state_d = (mx == '0) ? rtp_pkg::ST_IDLE : rtp_pkg::ST_PROD;
      rtp_pkg::ST_PROD: state_d = rtp_pkg::ST_SUMS;
      rtp_pkg::ST_SUMS: state_d = rtp_pkg::ST_DIV;
      rtp_pkg::ST_DIV:  if (last_div) state_d = rtp_pkg::ST_TERM;
      rtp_pkg::ST_TERM: if (last_term) state_d = rtp_pkg::ST_IDLE;
      default:          state_d = rtp_pkg::ST_IDLE;
    endcase
    if (cfg_hit && (state_q != rtp_pkg::ST_IDLE)) state_d = rtp_pkg::ST_NORM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= '0;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= COORD_BITS'(1) << FRAC_BITS;
      for (int i = 0; i < 3; i++) sh_q[i] <= '0;
      for (int k = 0; k < 9; k++) begin
        rot_q[k] <= ((k % 4) == 0) ? rtp_pkg::ONE_Q30 : '0;
      end
    end else begin
      if (cfg_hit) begin
        if (cfg_idx_i < rtp_pkg::REG_SX) q_q[cfg_idx_i[1:0]] <= cfg_data_i;
        else begin
          case (cfg_idx_i)
            rtp_pkg::REG_SX: sh_q[0] <= cfg_data_i;
            rtp_pkg::REG_SY: sh_q[1] <= cfg_data_i;
            rtp_pkg::REG_SZ: sh_q[2] <= cfg_data_i;
            default: ;
          endcase
        end
      end
      if ((state_q == rtp_pkg::ST_NORM) && (mx == '0)) begin
        for (int k = 0; k < 9; k++) begin
          rot_q[k] <= ((k % 4) == 0) ? rtp_pkg::ONE_Q30 : '0;
        end
      end
      if ((state_q == rtp_pkg::ST_TERM) && (sub_q == 2'd2)) begin
        rot_q[ecnt_q] <= EB'(ent);
      end
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      rtp_pkg::ST_NORM: begin
        for (int i = 0; i < 4; i++) qs_q[i] <= qs_d[i];
        dcnt_q <= '0;
        rem_q  <= '0;
        inv_q  <= '0;
        ecnt_q <= '0;
        sub_q  <= '0;
      end
      rtp_pkg::ST_PROD: begin
        pr_q[0] <= qs_q[0] * qs_q[0];
        pr_q[1] <= qs_q[1] * qs_q[1];
        pr_q[2] <= qs_q[2] * qs_q[2];
        pr_q[3] <= qs_q[3] * qs_q[3];
        pr_q[4] <= qs_q[0] * qs_q[1];
        pr_q[5] <= qs_q[2] * qs_q[3];
        pr_q[6] <= qs_q[0] * qs_q[2];
        pr_q[7] <= qs_q[1] * qs_q[3];
        pr_q[8] <= qs_q[1] * qs_q[2];
        pr_q[9] <= qs_q[0] * qs_q[3];
      end
      rtp_pkg::ST_SUMS: begin
        m_q <= n_sum[61:30];
        for (int k = 0; k < 9; k++) begin
          tm_q[k]   <= tmag[k][62:30];
          tneg_q[k] <= tval[k][63];
        end
      end
      rtp_pkg::ST_DIV: begin
        rem_q  <= qbit ? 32'(trial - {1'b0, m_q}) : trial[31:0];
        inv_q  <= {inv_q[IB-2:0], qbit};
        dcnt_q <= dcnt_q + 6'd1;
      end
      rtp_pkg::ST_TERM: begin
        case (sub_q)
          2'd0:    acc_q <= AB'(pp_lo);
          2'd1:    acc_q <= acc_q + (AB'(pp_hi) << IL);
          default: ;
        endcase
        if (sub_q == 2'd2) begin
          sub_q  <= '0;
          ecnt_q <= ecnt_q + 4'd1;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign rot_o   = rot_q;
  assign shift_o = sh_q;

endmodule

/* sv/rtp_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_lane
// One output coordinate: row times point, rounding, translation, saturation.
// ----------------------------------------------------------------------------
module rtp_lane #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [rtp_pkg::ENTRY_BITS-1:0] row_i [3],
  input  logic signed [COORD_BITS-1:0]          pt_i [3],
  input  logic signed [COORD_BITS-1:0]          shift_i,
  output logic signed [COORD_BITS-1:0]          res_o,
  output logic                                  clip_o
);

  localparam int unsigned PW = rtp_pkg::ENTRY_BITS + COORD_BITS;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned RW = SW - rtp_pkg::ROT_FRAC;
  localparam int unsigned VW = RW + 1;
  localparam logic signed [VW-1:0] HI = VW'((64'(1) << (COORD_BITS - 1)) - 64'(1));
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  logic signed [PW-1:0] prod_q [3];
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] rnd;
  logic signed [VW-1:0] val;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) prod_q[j] <= row_i[j] * pt_i[j];
    end
  end

  // round to nearest, ties toward plus infinity
  assign sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2])
             + (SW'(1) << (rtp_pkg::ROT_FRAC - 1));
  assign rnd = RW'(sum >>> rtp_pkg::ROT_FRAC);
  assign val = VW'(rnd) + VW'(shift_i);

  always_comb begin
    clip_o = 1'b0;
    res_o  = COORD_BITS'(val);
    if (val > HI) begin
      res_o  = COORD_BITS'(HI);
      clip_o = 1'b1;
    end else if (val < LO) begin
      res_o  = COORD_BITS'(LO);
      clip_o = 1'b1;
    end
  end

endmodule

/* sv/rtp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_checker
// Port-level checks on the rigid point transform, bound to the top level.
// ----------------------------------------------------------------------------
module rtp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cfg_we_i,
  input logic [2:0] cfg_idx_i
);

  // a held result item is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn under stall");

  // matrix rebuild blocks input
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i < rtp_pkg::NUM_REGS) |=> !in_ready)
    else $error("input taken while matrix rebuilds");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid)
    else $error("result item present straight after reset");

endmodule

bind rigid_transform_points_top rtp_checker u_rtp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .cfg_we_i (cfg_we_i),
  .cfg_idx_i(cfg_idx_i)
);

/* tb/rigid_transform_points_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_transform_points_top_test
// Streams points through the quaternion rigid transform under a range of
// quaternions and translations. A local copy of the matrix derivation and of
// the point arithmetic predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module rigid_transform_points_top_test;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_MAX  = 3000;
  localparam int SETTLE     = 100;

  typedef struct packed {
    logic [31:0] moved_x;
    logic [31:0] moved_y;
    logic [31:0] moved_z;
    logic        clipped;
  } moved_point_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [COORD_BITS-1:0] cfg_data_i;

  rtp_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  rtp_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  rigid_transform_points_top #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // local copy of the configuration and the derived matrix
  logic [31:0] cfg_shadow [7];
  longint      rot_q30 [9];
  moved_point_t pending_points [$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  hold_cnt;
  int  n_errors;
  int  quiet_cycles;

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint scale_term(longint t, longint unsigned inv);
    longint unsigned e;
    e = ((magnitude(t) >> 30) * inv) >> 32;
    return (t < 0) ? -longint'(e) : longint'(e);
  endfunction

  function automatic void derive_rotation();
    longint q [4];
    longint unsigned mx, a, m, inv;
    int len;
    longint x, y, z, w, n;
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      q[i] = longint'($signed(cfg_shadow[i]));
      if (magnitude(q[i]) > mx) mx = magnitude(q[i]);
    end
    for (int i = 0; i < 9; i++) rot_q30[i] = (i % 4 == 0) ? longint'(1) << 30 : 0;
    if (mx == 0) return;
    len = 0;
    while (len < 63 && (mx >> len) != 0) len++;
    for (int i = 0; i < 4; i++) begin
      a = magnitude(q[i]);
      a = (len > 30) ? (a >> (len - 30)) : (a << (30 - len));
      q[i] = (q[i] < 0) ? -longint'(a) : longint'(a);
    end
    x = q[0]; y = q[1]; z = q[2]; w = q[3];
    n = x * x + y * y + z * z + w * w;
    m = longint'(n) >> 30;
    inv = (longint'(1) << 62) / m;
    rot_q30[0] = (longint'(1) << 30) - scale_term(2 * (y * y + z * z), inv);
    rot_q30[1] = scale_term(2 * (x * y - z * w), inv);
    rot_q30[2] = scale_term(2 * (x * z + y * w), inv);
    rot_q30[3] = scale_term(2 * (x * y + z * w), inv);
    rot_q30[4] = (longint'(1) << 30) - scale_term(2 * (x * x + z * z), inv);
    rot_q30[5] = scale_term(2 * (y * z - x * w), inv);
    rot_q30[6] = scale_term(2 * (x * z - y * w), inv);
    rot_q30[7] = scale_term(2 * (y * z + x * w), inv);
    rot_q30[8] = (longint'(1) << 30) - scale_term(2 * (x * x + y * y), inv);
  endfunction

  function automatic moved_point_t transform_point(logic [31:0] px, logic [31:0] py,
                                                   logic [31:0] pz);
    moved_point_t res;
    longint p [3], ph [3], pl [3];
    longint sh, sl, ah, al, r, v;
    longint hi, lo;
    hi = 64'sd2147483647;
    lo = -hi - 1;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    res.clipped = 1'b0;
    for (int j = 0; j < 3; j++) begin
      ph[j] = p[j] >>> 16;
      pl[j] = p[j] - ph[j] * 65536;
    end
    for (int i = 0; i < 3; i++) begin
      sh = 0; sl = 0;
      for (int j = 0; j < 3; j++) begin
        sh += rot_q30[i * 3 + j] * ph[j];
        sl += rot_q30[i * 3 + j] * pl[j];
      end
      ah = sh >>> 14;
      al = sh - ah * 16384;
      r  = ah + ((al * 65536 + sl + (longint'(1) << 29)) >>> 30);
      v  = r + longint'($signed(cfg_shadow[4 + i]));
      if (v > hi) begin v = hi; res.clipped = 1'b1; end
      if (v < lo) begin v = lo; res.clipped = 1'b1; end
      case (i)
        0: res.moved_x = v[31:0];
        1: res.moved_y = v[31:0];
        default: res.moved_z = v[31:0];
      endcase
    end
    return res;
  endfunction

  // receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_req) begin
      hold_req     <= 1'b0;
      hold_cnt     <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_points.size() == 0) begin
          $error("result with no point pending");
          n_errors++;
        end else begin
          moved_point_t exp_pt;
          exp_pt = pending_points.pop_front();
          if (out_ch.moved_x !== exp_pt.moved_x) begin
            $error("moved_x expected %0d got %0d", $signed(exp_pt.moved_x), out_ch.moved_x);
            n_errors++;
          end
          if (out_ch.moved_y !== exp_pt.moved_y) begin
            $error("moved_y expected %0d got %0d", $signed(exp_pt.moved_y), out_ch.moved_y);
            n_errors++;
          end
          if (out_ch.moved_z !== exp_pt.moved_z) begin
            $error("moved_z expected %0d got %0d", $signed(exp_pt.moved_z), out_ch.moved_z);
            n_errors++;
          end
          if (out_ch.clipped !== exp_pt.clipped) begin
            $error("clipped expected %0b got %0b", exp_pt.clipped, out_ch.clipped);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_points.push_back(transform_point(px, py, pz));
  endtask

  task automatic drain_points();
    in_ch.valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  // written only while idle; the pause covers the matrix derivation
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    drain_points();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < rtp_pkg::NUM_REGS) begin
      cfg_shadow[idx] = value;
      derive_rotation();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_transform(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                                logic [31:0] qw, logic [31:0] sx, logic [31:0] sy,
                                logic [31:0] sz);
    write_reg(rtp_pkg::REG_QX, qx);
    write_reg(rtp_pkg::REG_QY, qy);
    write_reg(rtp_pkg::REG_QZ, qz);
    write_reg(rtp_pkg::REG_QW, qw);
    write_reg(rtp_pkg::REG_SX, sx);
    write_reg(rtp_pkg::REG_SY, sy);
    write_reg(rtp_pkg::REG_SZ, sz);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(255)
                                        : 32'h8000_0000 + $urandom_range(255);
    endcase
  endfunction

  task automatic stream_random(int count);
    for (int k = 0; k < count; k++) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_reset_identity();
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'hffff_ffff, 32'h0, 32'h8000_0000);
  endtask

  task automatic test_extremes();
    logic [31:0] corners [4] = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    // 90 degrees about z with a unit quaternion, then extreme points
    load_transform(32'h0, 32'h0, 32'h0000_b505, 32'h0000_b505, 32'h0, 32'h0, 32'h0);
    for (int k = 0; k < 4; k++) send_point(corners[k], corners[3 - k], corners[(k + 1) % 4]);
    // saturation both ways through the translation
    load_transform(32'h0, 32'h0, 32'h0, 32'h0001_0000,
                   32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    for (int k = 0; k < 4; k++) send_point(corners[k], corners[(k + 2) % 4], corners[k]);
    // zero quaternion gives the identity, unused index changes nothing
    load_transform(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    write_reg(rtp_pkg::NUM_REGS, $urandom());
    for (int k = 0; k < 4; k++) send_point(corners[k], corners[k], corners[3 - k]);
    // most negative components and a rounding tie
    load_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h0, 32'h0, 32'h0);
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0000_0001);
    send_point(corners[2], corners[3], corners[1]);
    load_transform(32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(corners[3], corners[2], corners[0]);
  endtask

  task automatic test_random_transforms(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph % 3 == 0)
        load_transform($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
      else
        load_transform(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord());
      stream_random(per_phase);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    stream_random(60);
    drain_points();
    stream_random(40);
  endtask

  initial begin
    n_errors      = 0;
    quiet_cycles  = 0;
    hold_req      = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 71;
    rst_ni        = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= rtp_pkg::REG_QX;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    for (int i = 0; i < 7; i++) cfg_shadow[i] = '0;
    cfg_shadow[rtp_pkg::REG_QW] = 32'h0001_0000;
    derive_rotation();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_extremes();
    test_random_transforms(3, 180);
    send_idle_pct = 71;
    recv_idle_pct = 22;
    test_random_transforms(3, 180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_transforms(3, 180);

    drain_points();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
